### rtl/top_two_pair_action_decoder_defines.svh
// ----------------------------------------------------------------------------
// Top-two pair action decoder: assertion macros
// Shared property forms for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef TOP_TWO_PAIR_ACTION_DECODER_DEFINES_SVH
`define TOP_TWO_PAIR_ACTION_DECODER_DEFINES_SVH

// Same-cycle implication, clocked on clk, held off during reset
`define TPAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, held off during reset
`define TPAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/tpad_pkg.sv
// ----------------------------------------------------------------------------
// Top-two pair action decoder package
// Sizes, register map, reset values and the sequencer's control store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpad_pkg;

  // Default parameter values
  localparam int DEF_MAX_OUTPUTS = 64;
  localparam int DEF_MAX_INPUTS  = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // Fixed field and register widths
  localparam int CODE_W   = 12;
  localparam int OCOUNT_W = 7;
  localparam int ICOUNT_W = 11;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;

  // Register map (selected by address bit 2)
  localparam logic REG_OUTPUT_COUNT = 1'b0;
  localparam logic REG_INPUT_COUNT  = 1'b1;

  localparam logic [OCOUNT_W-1:0] OUTPUT_COUNT_RESET = OCOUNT_W'(2);
  localparam logic [ICOUNT_W-1:0] INPUT_COUNT_RESET  = ICOUNT_W'(1);

  // Sequencer control store
  localparam int STEP_W = 3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MUL,
    OP_RANK,
    OP_MOD,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  localparam logic [STEP_W-1:0] STEP_WAIT = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_RANK = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MOD  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT = 3'd4;
  localparam logic [STEP_W-1:0] STEP_RET  = 3'd5;

  // One control word per step; a taken condition jumps, else fall through
  function automatic ctrl_t tpad_ucode(input logic [STEP_W-1:0] step);
    ctrl_t cw;
    case (step)
      STEP_WAIT: cw = '{op: OP_NOP,  cond: COND_NO_START, target: STEP_WAIT};
      STEP_MUL:  cw = '{op: OP_MUL,  cond: COND_NEVER,    target: STEP_WAIT};
      STEP_RANK: cw = '{op: OP_RANK, cond: COND_NEVER,    target: STEP_WAIT};
      STEP_MOD:  cw = '{op: OP_MOD,  cond: COND_MORE,     target: STEP_MOD};
      STEP_EMIT: cw = '{op: OP_EMIT, cond: COND_OUT_BUSY, target: STEP_EMIT};
      STEP_RET:  cw = '{op: OP_NOP,  cond: COND_ALWAYS,   target: STEP_WAIT};
      default:   cw = '{op: OP_NOP,  cond: COND_ALWAYS,   target: STEP_WAIT};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

### rtl/tpad_in_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one signed network output sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tpad_in_if
  import tpad_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

`default_nettype wire

### rtl/tpad_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one signed action code and its valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tpad_out_if
  import tpad_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic signed [CODE_W-1:0] action_code;
  logic                     valid_res;

  modport source (output valid, output action_code, output valid_res, input ready);
  modport sink   (input valid, input action_code, input valid_res, output ready);

endinterface

`default_nettype wire

### rtl/top_two_pair_action_decoder.sv
// ----------------------------------------------------------------------------
// Top-two pair action decoder
// Tracks the two largest samples above -1.0 in a vector and turns the pair
// of their positions into a signed action code through a small sequencer.
// ----------------------------------------------------------------------------
// Each request on sample_ch is one sample and is taken while the sequencer waits.
// Samples that are not the last of a vector produce no result. The last
// sample hands the two positions to a microcoded sequencer and the sample
// channel stays closed until it returns to its wait step: one multiply step,
// one rank step, 2*clog2(MAX_OUTPUTS+1) restoring-division steps (14 at the
// default size) for the modulo, an emit step that holds while the result
// register is still full, and a return step. The result register decouples
// the result channel, so further samples of the next vector are taken while
// a result waits. output_count and input_count sit at byte addresses 0 and 4;
// a write is seen from the next sample on and does not clear the tracking
// state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "top_two_pair_action_decoder_defines.svh"

module top_two_pair_action_decoder
  import tpad_pkg::*;
#(
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  tpad_in_if.sink                 sample_ch,
  tpad_out_if.source              result_ch
);

  localparam int POS_W  = $clog2(MAX_OUTPUTS + 1);
  localparam int IN_W   = $clog2(MAX_INPUTS + 1);
  localparam int MOD_W  = IN_W + 1;
  localparam int RANK_W = 2 * POS_W;
  localparam int CNT_W  = $clog2(RANK_W + 1);

  localparam logic signed [SAMPLE_BITS-1:0] MINUS_ONE = {2'b11, {(SAMPLE_BITS-2){1'b0}}};

  // Configuration registers
  logic [OCOUNT_W-1:0] output_count;
  logic [ICOUNT_W-1:0] input_count;
  logic                cfg_write;

  // Tracking state
  logic signed [SAMPLE_BITS-1:0] best_value, second_value;
  logic        [POS_W-1:0]       best_pos, second_pos, sample_counter;

  // Sequencer datapath
  logic [STEP_W-1:0] pc, pc_next;
  ctrl_t             cw;
  logic              take;
  logic [POS_W-1:0]  a_pos, b_pos, n_lat;
  logic [MOD_W-1:0]  m_lat;
  logic              res_ok;
  logic [RANK_W-1:0] p1, p2, rank_sh;
  logic [MOD_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;

  // Result register
  logic                     out_valid, out_ok;
  logic signed [CODE_W-1:0] out_code;

  // Combinational helpers
  logic [POS_W-1:0]              n_eff, pos, nbp, nsp, am1;
  logic [IN_W-1:0]               i_eff;
  logic [MOD_W-1:0]              m_eff;
  logic signed [SAMPLE_BITS-1:0] nbv, nsv;
  logic                          accept, last, start;
  logic [MOD_W:0]                trial;
  logic [MOD_W-1:0]              mag;
  logic signed [MOD_W-1:0]       code_full;

  // ---- configuration port ----
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_count <= OUTPUT_COUNT_RESET;
      input_count  <= INPUT_COUNT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_OUTPUT_COUNT: output_count <= pwdata[OCOUNT_W-1:0];
        REG_INPUT_COUNT:  input_count  <= pwdata[ICOUNT_W-1:0];
        default:          output_count <= output_count;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OUTPUT_COUNT: prdata = PDATA_W'(output_count);
      REG_INPUT_COUNT:  prdata = PDATA_W'(input_count);
      default:          prdata = '0;
    endcase
  end

  // Clamp the counts into their supported ranges
  always_comb begin
    if (output_count < OCOUNT_W'(2)) begin
      n_eff = POS_W'(2);
    end else if (int'(output_count) > MAX_OUTPUTS) begin
      n_eff = POS_W'(MAX_OUTPUTS);
    end else begin
      n_eff = POS_W'(output_count);
    end
    if (input_count == '0) begin
      i_eff = IN_W'(1);
    end else if (int'(input_count) > MAX_INPUTS) begin
      i_eff = IN_W'(MAX_INPUTS);
    end else begin
      i_eff = IN_W'(input_count);
    end
    m_eff = {i_eff, 1'b0};
  end

  // ---- sample tracking ----
  assign sample_ch.ready = (pc == STEP_WAIT);
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign pos             = sample_counter + 1'b1;
  assign last            = (pos >= n_eff);
  assign start           = accept && last;

  // Compare and update the top two, earlier sample keeps ties
  always_comb begin
    nbv = best_value;
    nbp = best_pos;
    nsv = second_value;
    nsp = second_pos;
    if (sample_ch.sample > best_value) begin
      nsv = best_value;
      nsp = best_pos;
      nbv = sample_ch.sample;
      nbp = pos;
    end else if (sample_ch.sample > second_value) begin
      nsv = sample_ch.sample;
      nsp = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_value     <= MINUS_ONE;
      second_value   <= MINUS_ONE;
      best_pos       <= '0;
      second_pos     <= '0;
      sample_counter <= '0;
    end else if (accept) begin
      if (last) begin
        best_value     <= MINUS_ONE;
        second_value   <= MINUS_ONE;
        best_pos       <= '0;
        second_pos     <= '0;
        sample_counter <= '0;
      end else begin
        best_value     <= nbv;
        second_value   <= nsv;
        best_pos       <= nbp;
        second_pos     <= nsp;
        sample_counter <= pos;
      end
    end
  end

  // Hand the ordered pair and the vector's counts to the sequencer
  always_ff @(posedge clk) begin
    if (start) begin
      a_pos  <= (nbp < nsp) ? nbp : nsp;
      b_pos  <= (nbp < nsp) ? nsp : nbp;
      res_ok <= (nsp != '0);
      n_lat  <= n_eff;
      m_lat  <= m_eff;
    end
  end

  // ---- sequencer ----
  assign cw = tpad_ucode(pc);

  always_comb begin
    case (cw.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_START: take = !start;
      COND_MORE:     take = (cnt != CNT_W'(1));
      COND_OUT_BUSY: take = out_valid;
      default:       take = 1'b0;
    endcase
    pc_next = take ? cw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // ---- datapath ----
  assign am1   = a_pos - 1'b1;
  assign trial = {rem, rank_sh[RANK_W-1]};
  assign mag   = (rem >> 1) + 1'b1;

  always_comb begin
    if (rem[0]) begin
      code_full = -$signed(mag);
    end else begin
      code_full = $signed(mag);
    end
  end

  // Rank pieces, then one restoring-division bit per step
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_MUL: begin
        p1 <= RANK_W'(am1) * RANK_W'(n_lat);
        p2 <= RANK_W'(am1) * RANK_W'(a_pos);
      end
      OP_RANK: begin
        rank_sh <= p1 - (p2 >> 1) + RANK_W'(b_pos - a_pos - 1'b1);
        rem     <= '0;
        cnt     <= CNT_W'(RANK_W);
      end
      OP_MOD: begin
        if (trial >= {1'b0, m_lat}) begin
          rem <= MOD_W'(trial - {1'b0, m_lat});
        end else begin
          rem <= trial[MOD_W-1:0];
        end
        rank_sh <= rank_sh << 1;
        cnt     <= cnt - 1'b1;
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_EMIT && !out_valid) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_EMIT && !out_valid) begin
      out_ok   <= res_ok;
      out_code <= res_ok ? CODE_W'(code_full) : '0;
    end
  end

  assign result_ch.valid       = out_valid;
  assign result_ch.action_code = out_code;
  assign result_ch.valid_res   = out_ok;

  // ---- checks ----
  `TPAD_ASSERT_NEXT(a_start_clears, start, pc == STEP_MUL && best_pos == '0 && second_pos == '0 && sample_counter == '0, "last sample did not start the program and clear tracking")
  `TPAD_ASSERT_NOW(a_mod_count, pc == STEP_MOD, cnt != '0, "division loop ran past its bit count")
  `TPAD_ASSERT_NOW(a_rem_bound, pc == STEP_MOD, rem < m_lat, "partial remainder not below modulus")
  `TPAD_ASSERT_NOW(a_invalid_zero, out_valid && !out_ok, out_code == '0, "invalid result with a nonzero code")

endmodule

`default_nettype wire
